FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/iirbq_pkg.sv
// shared types, constants and a helper function of the biquad filter
`timescale 1ns / 1ps

package iirbq_pkg;

   localparam int DATA_WIDTH = 8;
   localparam int COEF_WIDTH = 8;
   localparam int STATE_WIDTH = 16;
   localparam int OUT_WIDTH = 16;

   // truncated product keeps STATE_WIDTH+1 significant bits
   localparam int PROD_WIDTH = COEF_WIDTH + STATE_WIDTH;
   localparam int QUOT_WIDTH = STATE_WIDTH + 1;
   localparam int MAX_IN_WIDTH = (QUOT_WIDTH > COEF_WIDTH)
      ? ((QUOT_WIDTH > DATA_WIDTH) ? QUOT_WIDTH : DATA_WIDTH)
      : ((COEF_WIDTH > DATA_WIDTH) ? COEF_WIDTH : DATA_WIDTH);
   localparam int ACC_WIDTH = MAX_IN_WIDTH + 3;

   // alignment of input and output between sample and coefficient scales
   localparam int ALIGN_UP = (COEF_WIDTH >= DATA_WIDTH) ? COEF_WIDTH - DATA_WIDTH : 0;
   localparam int ALIGN_DN = (DATA_WIDTH > COEF_WIDTH) ? DATA_WIDTH - COEF_WIDTH : 0;
   localparam int WIDE_WIDTH = ACC_WIDTH + ALIGN_DN;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_A1 = 3'd0,
      CSR_A2 = 3'd1,
      CSR_B0 = 3'd2,
      CSR_B1 = 3'd3,
      CSR_B2 = 3'd4
   } csr_index_type;

   localparam logic signed [COEF_WIDTH-1:0] A1_RESET = COEF_WIDTH'(-48);
   localparam logic signed [COEF_WIDTH-1:0] A2_RESET = COEF_WIDTH'(25);
   localparam logic signed [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(26);
   localparam logic signed [COEF_WIDTH-1:0] B1_RESET = COEF_WIDTH'(52);
   localparam logic signed [COEF_WIDTH-1:0] B2_RESET = COEF_WIDTH'(26);

   // operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_A1_D0,
      MUL_A2_D1,
      MUL_B1_D0,
      MUL_B2_D1,
      MUL_B0_W
   } mul_sel_type;

   // where the registered product goes
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_FB,
      ACC_FF
   } acc_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        w_load;
      logic        shift_delay;
      logic        out_load;
   } dp_cmd_type;

   localparam logic signed [WIDE_WIDTH-1:0] SAT_MAX = WIDE_WIDTH'(32767);
   localparam logic signed [WIDE_WIDTH-1:0] SAT_MIN = WIDE_WIDTH'(-32768);

   function automatic logic signed [OUT_WIDTH-1:0] sat16(input logic signed [WIDE_WIDTH-1:0] v);
      logic signed [OUT_WIDTH-1:0] r;
      if (v > SAT_MAX) r = OUT_WIDTH'(SAT_MAX);
      else if (v < SAT_MIN) r = OUT_WIDTH'(SAT_MIN);
      else r = v[OUT_WIDTH-1:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/iirbq_ctrl.sv
// sequencer that steps the shared multiplier through one sample
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirbq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output iirbq_pkg::dp_cmd_type   cmd
);
   import iirbq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FB1,
      ST_FB2,
      ST_FF1,
      ST_FF2,
      ST_FF3,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_A1_D0;
      cmd.acc_sel  = ACC_NONE;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = ST_FB1;
         end
         ST_FB1: begin
            cmd.acc_sel = ACC_FB;
            cmd.mul_sel = MUL_A2_D1;
            state_in    = ST_FB2;
         end
         ST_FB2: begin
            cmd.acc_sel = ACC_FB;
            cmd.mul_sel = MUL_B1_D0;
            state_in    = ST_FF1;
         end
         ST_FF1: begin
            cmd.acc_sel = ACC_FF;
            cmd.w_load  = 1'b1;
            cmd.mul_sel = MUL_B2_D1;
            state_in    = ST_FF2;
         end
         ST_FF2: begin
            cmd.acc_sel = ACC_FF;
            cmd.mul_sel = MUL_B0_W;
            state_in    = ST_FF3;
         end
         ST_FF3: begin
            cmd.acc_sel     = ACC_FF;
            cmd.shift_delay = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            cmd.out_load = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_FB1)
   `ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `ASSERT_NEXT(a_shift_then_done, clock, reset, cmd.shift_delay, state_ff == ST_DONE)

endmodule

FILE: hw/rtl/iirbq_dp.sv
// datapath: coefficients, shared multiplier, accumulators, delay line, output register
`timescale 1ns / 1ps

module iirbq_dp (
   input  logic                                          clock,
   input  logic                                          reset,
   input  iirbq_pkg::dp_cmd_type                         cmd,
   input  logic signed [iirbq_pkg::DATA_WIDTH-1:0]       req_sample,
   input  logic                                          csr_we,
   input  logic [iirbq_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic signed [iirbq_pkg::COEF_WIDTH-1:0]       csr_wdata,
   output logic signed [iirbq_pkg::OUT_WIDTH-1:0]        rsp_sample
);
   import iirbq_pkg::*;

   logic signed [COEF_WIDTH-1:0]  a1_ff, a2_ff, b0_ff, b1_ff, b2_ff;
   logic signed [COEF_WIDTH-1:0]  a1_in, a2_in, b0_in, b1_in, b2_in;
   logic signed [STATE_WIDTH-1:0] d0_ff, d1_ff, w_ff;
   logic signed [STATE_WIDTH-1:0] d0_in, d1_in, w_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]   fb_ff, ff_ff, fb_in, ff_in;
   logic signed [OUT_WIDTH-1:0]   rsp_sample_ff, rsp_sample_in;

   logic signed [COEF_WIDTH-1:0]  coef_opd;
   logic signed [STATE_WIDTH-1:0] data_opd;
   logic signed [PROD_WIDTH-1:0]  quot;
   logic signed [ACC_WIDTH-1:0]   quot_acc;
   logic signed [ACC_WIDTH-1:0]   x_ext, x_aligned;
   logic signed [WIDE_WIDTH-1:0]  y_ext, y_aligned;

   assign rsp_sample = rsp_sample_ff;

   always_comb begin
      // operand select for the one multiplier
      case (cmd.mul_sel)
         MUL_A1_D0: begin coef_opd = a1_ff; data_opd = d0_ff; end
         MUL_A2_D1: begin coef_opd = a2_ff; data_opd = d1_ff; end
         MUL_B1_D0: begin coef_opd = b1_ff; data_opd = d0_ff; end
         MUL_B2_D1: begin coef_opd = b2_ff; data_opd = d1_ff; end
         MUL_B0_W:  begin coef_opd = b0_ff; data_opd = w_ff;  end
         default:   begin coef_opd = a1_ff; data_opd = d0_ff; end
      endcase
      prod_in = PROD_WIDTH'(coef_opd) * PROD_WIDTH'(data_opd);

      // floor truncation of the registered product
      quot     = prod_ff >>> (COEF_WIDTH - 1);
      quot_acc = ACC_WIDTH'(quot);

      x_ext     = ACC_WIDTH'(req_sample);
      x_aligned = (x_ext <<< ALIGN_UP) >>> ALIGN_DN;

      fb_in = fb_ff;
      ff_in = ff_ff;
      if (cmd.load) begin
         fb_in = x_aligned;
         ff_in = '0;
      end else begin
         case (cmd.acc_sel)
            ACC_FB:  fb_in = fb_ff - quot_acc;
            ACC_FF:  ff_in = ff_ff + quot_acc;
            default: ;
         endcase
      end

      w_in = cmd.w_load ? sat16(WIDE_WIDTH'(fb_ff)) : w_ff;

      d0_in = d0_ff;
      d1_in = d1_ff;
      if (cmd.shift_delay) begin
         d1_in = d0_ff;
         d0_in = w_ff;
      end

      y_ext         = WIDE_WIDTH'(ff_ff);
      y_aligned     = (y_ext <<< ALIGN_DN) >>> ALIGN_UP;
      rsp_sample_in = cmd.out_load ? sat16(y_aligned) : rsp_sample_ff;

      a1_in = a1_ff;
      a2_in = a2_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_A1:  a1_in = csr_wdata;
            CSR_A2:  a2_in = csr_wdata;
            CSR_B0:  b0_in = csr_wdata;
            CSR_B1:  b1_in = csr_wdata;
            CSR_B2:  b2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff <= A1_RESET;
         a2_ff <= A2_RESET;
         b0_ff <= B0_RESET;
         b1_ff <= B1_RESET;
         b2_ff <= B2_RESET;
         d0_ff <= '0;
         d1_ff <= '0;
      end else begin
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         b0_ff <= b0_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      fb_ff         <= fb_in;
      ff_ff         <= ff_in;
      w_ff          <= w_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

FILE: hw/rtl/iir_biquad_df2_truncated_core.sv
// top level of the second-order direct form ii iir filter with truncated products
`timescale 1ns / 1ps
// a req beat passes ST_FB1 to ST_FF3, then ST_DONE loads the output register when free
// a new sample is taken only when idle: accept, five multiply-accumulate steps, output load
// a finished sample waits in the output register while the next req beat is taken
// reset: synchronous, active high; clears the delay line and restores default coefficients
// coefficient writes take effect at the next clock edge and must happen while idle

module iir_biquad_df2_truncated_core (
   input  logic                                      clock,
   input  logic                                      reset,
   // request stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,   // [7:0] sample_in
   // response stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [15:0]                               rsp_tdata,   // [15:0] sample_out
   // coefficient write port
   input  logic                                      csr_we,
   input  logic [iirbq_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [iirbq_pkg::COEF_WIDTH-1:0]          csr_wdata
);
   import iirbq_pkg::*;

   // command bundle from the sequencer to the datapath
   dp_cmd_type                  cmd;
   logic signed [OUT_WIDTH-1:0] rsp_sample;

   iirbq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // sample fills tdata exactly, so no padding bits are dropped
   iirbq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_sample (signed'(req_tdata[DATA_WIDTH-1:0])),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (signed'(csr_wdata)),
      .rsp_sample (rsp_sample)
   );

   assign rsp_tdata = rsp_sample;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench of the biquad core: stream drivers, scoreboard and run control
`timescale 1ns / 1ps

module tb_top;
   import iirbq_pkg::*;

   // run shape
   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int LATENCY_CYCLES   = 7;       // extra wait that wait_drained adds once nothing is owed
   localparam int CYCLE_LIMIT      = 600000;  // several times the slowest legal run
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int NUM_COEFS        = 5;
   localparam int RAMP_ITEMS       = 13;      // enough beats for w to run into the rail
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 110;
   localparam int HOLD_PHASE       = 2;       // phase in which the sink holds off for long
   localparam int PAUSE_PHASE      = 5;       // phase in which the source drains mid-stream

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic signed [OUT_WIDTH-1:0]  result_type;

   localparam coef_type   COEF_MAX   = coef_type'((1 << (COEF_WIDTH - 1)) - 1);
   localparam coef_type   COEF_MIN   = coef_type'(-(1 << (COEF_WIDTH - 1)));
   localparam sample_type SAMPLE_MAX = sample_type'((1 << (DATA_WIDTH - 1)) - 1);
   localparam sample_type SAMPLE_MIN = sample_type'(-(1 << (DATA_WIDTH - 1)));
   localparam longint     OUT_MAX    = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
   localparam longint     OUT_MIN    = -(longint'(1) <<< (OUT_WIDTH - 1));

   typedef struct packed {
      coef_type a1;
      coef_type a2;
      coef_type b0;
      coef_type b1;
      coef_type b2;
   } coef_set_type;

   // how a phase picks its coefficients
   typedef enum {
      SET_RANDOM,
      SET_ALL_MAX,
      SET_ALL_MIN,
      SET_RESET,
      SET_CORNERS,
      SET_GENTLE
   } set_kind_type;

   // tracks the filter state and holds the filtered samples still owed by the core
   class biquad_scoreboard;
      coef_type    a1, a2, b0, b1, b2;
      result_type  w_z1, w_z2;
      result_type  expected_q[$];
      int unsigned mismatches;
      int unsigned samples_in;
      int unsigned samples_out;

      function new();
         a1 = A1_RESET;
         a2 = A2_RESET;
         b0 = B0_RESET;
         b1 = B1_RESET;
         b2 = B2_RESET;
         w_z1 = '0;
         w_z2 = '0;
         mismatches = 0;
         samples_in = 0;
         samples_out = 0;
      endfunction

      function void write_coef(logic [CSR_INDEX_WIDTH-1:0] idx, coef_type val);
         case (idx)
            CSR_A1: a1 = val;
            CSR_A2: a2 = val;
            CSR_B0: b0 = val;
            CSR_B1: b1 = val;
            CSR_B2: b2 = val;
            default: ;
         endcase
      endfunction

      // product with the fraction bits floored away
      function longint trunc_mul(longint c, longint d);
         return (c * d) >>> (COEF_WIDTH - 1);
      endfunction

      function result_type clip16(longint v);
         if (v > OUT_MAX) return result_type'(OUT_MAX);
         if (v < OUT_MIN) return result_type'(OUT_MIN);
         return result_type'(v);
      endfunction

      function void note_sample(sample_type x);
         longint     xa, fb, ff, y;
         result_type w;
         xa = (longint'(x) <<< ALIGN_UP) >>> ALIGN_DN;
         fb = -(trunc_mul(a1, w_z1) + trunc_mul(a2, w_z2));
         ff = trunc_mul(b1, w_z1) + trunc_mul(b2, w_z2);
         w  = clip16(xa + fb);
         y  = trunc_mul(b0, w) + ff;
         y  = (y >>> ALIGN_UP) <<< ALIGN_DN;
         w_z2 = w_z1;
         w_z1 = w;
         expected_q.push_back(clip16(y));
         samples_in++;
      endfunction

      function void check_sample(result_type actual);
         result_type want;
         samples_out++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $error("sample_out: expected nothing, actual %0d", actual);
         end else begin
            want = expected_q.pop_front();
            if (actual !== want) begin
               mismatches++;
               $error("sample_out: expected %0d, actual %0d", want, actual);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // dut ports
   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [7:0]                 req_tdata;    // [7:0] sample_in
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [15:0]                rsp_tdata;    // [15:0] sample_out
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [COEF_WIDTH-1:0]      csr_wdata;

   biquad_scoreboard sb;
   bit               hold_off_req;   // asks the sink for one long hold-off
   bit               no_idle;        // both sides run flat out while set
   int               cycle_count = 0;
   int unsigned      settings_count = 0;
   set_kind_type     phase_kind [RANDOM_PHASES];

   iir_biquad_df2_truncated_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("iir_biquad_df2_truncated_core test failed");
         $finish;
      end
   end

   // idle length for either side: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic coef_type pick_coef(set_kind_type kind, coef_type reset_value);
      coef_type corners [5];
      corners = '{COEF_MIN, COEF_MAX, coef_type'(0), coef_type'(-1), coef_type'(1)};
      case (kind)
         SET_ALL_MAX: return COEF_MAX;
         SET_ALL_MIN: return COEF_MIN;
         SET_RESET:   return reset_value;
         SET_CORNERS: return corners[$urandom_range(4)];
         SET_GENTLE:  return coef_type'(int'($urandom_range(64)) - 32);
         default:     return coef_type'($urandom);
      endcase
   endfunction

   function automatic coef_set_type make_set(set_kind_type kind);
      coef_set_type s;
      s.a1 = pick_coef(kind, A1_RESET);
      s.a2 = pick_coef(kind, A2_RESET);
      s.b0 = pick_coef(kind, B0_RESET);
      s.b1 = pick_coef(kind, B1_RESET);
      s.b2 = pick_coef(kind, B2_RESET);
      return s;
   endfunction

   // mostly uniform samples, with the rails and the values around zero mixed in
   function automatic sample_type pick_sample();
      sample_type corners [5];
      corners = '{SAMPLE_MAX, SAMPLE_MIN, sample_type'(0), sample_type'(1), sample_type'(-1)};
      if ($urandom_range(99) < 75) return sample_type'($urandom);
      return corners[$urandom_range(4)];
   endfunction

   // one sample beat on the req side, noted in the scoreboard at the accepting edge
   task automatic send_sample(input sample_type x);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(x);
   endtask

   // stop offering and let every owed sample come out, plus the pipeline depth
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes of all five coefficients and one to an unmapped index past them
   task automatic program_coefs(input coef_set_type s);
      logic [CSR_INDEX_WIDTH-1:0] idx [NUM_COEFS+1];
      coef_type                   val [NUM_COEFS+1];
      idx[0] = CSR_A1;  val[0] = s.a1;
      idx[1] = CSR_A2;  val[1] = s.a2;
      idx[2] = CSR_B0;  val[2] = s.b0;
      idx[3] = CSR_B1;  val[3] = s.b1;
      idx[4] = CSR_B2;  val[4] = s.b2;
      // unmapped index, the core has to drop it
      idx[NUM_COEFS] = CSR_INDEX_WIDTH'($urandom_range(2 ** CSR_INDEX_WIDTH - 1, NUM_COEFS));
      val[NUM_COEFS] = coef_type'($urandom);
      for (int i = 0; i <= NUM_COEFS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.write_coef(idx[i], val[i]);
      end
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // rsp side: check every beat, stall at random, one long hold-off on request
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(99) < 30) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_off_req = 1'b0;
      no_idle = 1'b0;
      phase_kind = '{SET_RANDOM, SET_ALL_MAX, SET_GENTLE, SET_ALL_MIN, SET_RESET,
                     SET_CORNERS, SET_RANDOM, SET_GENTLE, SET_CORNERS, SET_RANDOM};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // default coefficients out of reset, zero, the input rails and minus one
      send_sample(sample_type'(0));
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_type'(-1));
      wait_drained();

      // both feedback taps at minus one: w climbs into the upper rail, y clips high
      program_coefs(coef_set_type'{COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX});
      repeat (RAMP_ITEMS) send_sample(SAMPLE_MAX);
      wait_drained();

      // no feedback flushes the delay line while inverting taps drive y into the lower rail
      program_coefs(coef_set_type'{coef_type'(0), coef_type'(0), COEF_MIN, COEF_MIN, COEF_MIN});
      send_sample(sample_type'(1));
      send_sample(sample_type'(0));
      wait_drained();

      // same runaway feedback from the negative side: w and y clip low
      program_coefs(coef_set_type'{COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX});
      repeat (RAMP_ITEMS) send_sample(SAMPLE_MIN);
      wait_drained();

      // random phases, each under its own coefficient set
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_coefs(make_set(phase_kind[p]));
         no_idle = (p % 4 == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sink stops for a long while, source keeps offering until the core backs up
            if (p == HOLD_PHASE && n == 20) hold_off_req = 1'b1;
            // source goes quiet until the core has nothing left to deliver
            if (p == PAUSE_PHASE && n == 50) wait_drained();
            send_sample(pick_sample());
         end
         wait_drained();
      end
      no_idle = 1'b0;

      $display("run: %0d samples sent, %0d filtered samples checked, %0d coefficient sets",
               sb.samples_in, sb.samples_out, settings_count);
      $display("run: rail clipping of state and output, unmapped writes, long sink stall, drain");
      if (sb.mismatches == 0) begin
         $display("iir_biquad_df2_truncated_core test passed");
      end else begin
         $display("iir_biquad_df2_truncated_core test failed");
      end
      $finish;
   end

endmodule
